/* rtl/ilrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ilrc_pkg;

    localparam int unsigned CharWidth = 8;
    localparam int unsigned MagWidth  = 128;
    localparam int unsigned FitWidth  = 10;
    localparam int unsigned OutWidth  = 16;
    localparam int unsigned NumTypes  = 5;

    localparam logic [CharWidth-1:0] ChPlus     = 8'h2B;
    localparam logic [CharWidth-1:0] ChMinus    = 8'h2D;
    localparam logic [CharWidth-1:0] ChZero     = 8'h30;
    localparam logic [CharWidth-1:0] ChNine     = 8'h39;
    localparam logic [CharWidth-1:0] ChUpperA   = 8'h41;
    localparam logic [CharWidth-1:0] ChUpperF   = 8'h46;
    localparam logic [CharWidth-1:0] ChUpperX   = 8'h58;
    localparam logic [CharWidth-1:0] ChLowerA   = 8'h61;
    localparam logic [CharWidth-1:0] ChLowerF   = 8'h66;
    localparam logic [CharWidth-1:0] ChLowerX   = 8'h78;

    // Parse phase, one-hot
    typedef enum logic [6:0] {
        PH_START  = 7'b0000001,
        PH_SIGN   = 7'b0000010,
        PH_ZERO   = 7'b0000100,
        PH_DEC    = 7'b0001000,
        PH_HEXPFX = 7'b0010000,
        PH_HEX    = 7'b0100000,
        PH_BAD    = 7'b1000000
    } phase_t;

endpackage

`default_nettype wire

/* rtl/integer_literal_range_classifier.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake                     | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] char_code, tlast last_char
// m_axis    | out | m_axis_tvalid / m_axis_tready | tdata[0] is_integer, [10:1] fit_mask,
//           |     |                               | [11] is_negative, [15:12] zero
//
// One character per cycle sustained. A character goes into an input register, then
// the parse state and the 128-bit shift-add by 10 or 16 update from it; on the
// last character the final magnitude lands in the result register and the range
// checks drive m_axis_tdata from it. A waiting result stalls only a following last
// character; other characters keep flowing. rst_n clears the parse state and both
// valid flags asynchronously.

module integer_literal_range_classifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // last_char
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // [0] is_integer, [10:1] fit_mask,
                                             // [11] is_negative, [15:12] zero
);

    localparam int unsigned MW = ilrc_pkg::MagWidth;

    // Input register
    logic                              in_valid_reg;
    logic [ilrc_pkg::CharWidth-1:0]    in_char_reg;
    logic                              in_last_reg;

    // Parse state
    ilrc_pkg::phase_t                  phase_reg, phase_next;
    logic                              neg_reg, neg_next;
    logic                              hex_reg, hex_next;
    logic [MW-1:0]                     mag_reg, mag_next;
    logic                              ovf_reg, ovf_next;

    // Result register
    logic                              out_valid_reg;
    logic                              out_ok_reg;
    logic                              out_neg_reg;
    logic                              out_ovf_reg;
    logic [MW-1:0]                     out_mag_reg;

    logic                              proc;
    logic                              is_dec;
    logic                              is_hex;
    logic [3:0]                        dec_val;
    logic [3:0]                        hex_val;
    logic                              acc_en;
    logic                              acc_hex;
    logic [3:0]                        acc_digit;
    logic [MW+3:0]                     wide;
    logic [MW+3:0]                     prod;
    logic [MW+3:0]                     sum;
    logic                              ok_now;
    logic [ilrc_pkg::FitWidth-1:0]     fit;

    // Consume the held character unless it is a last one with the result slot busy
    assign proc          = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign m_axis_tvalid = out_valid_reg;

    always_comb
    begin
        is_dec  = (in_char_reg >= ilrc_pkg::ChZero) && (in_char_reg <= ilrc_pkg::ChNine);
        dec_val = 4'(in_char_reg - ilrc_pkg::ChZero);
        is_hex  = 1'b1;
        hex_val = dec_val;
        if (is_dec)
        begin
            hex_val = dec_val;
        end
        else if ((in_char_reg >= ilrc_pkg::ChLowerA) && (in_char_reg <= ilrc_pkg::ChLowerF))
        begin
            hex_val = 4'(in_char_reg - ilrc_pkg::ChLowerA + 8'd10);
        end
        else if ((in_char_reg >= ilrc_pkg::ChUpperA) && (in_char_reg <= ilrc_pkg::ChUpperF))
        begin
            hex_val = 4'(in_char_reg - ilrc_pkg::ChUpperA + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        phase_next = ilrc_pkg::PH_BAD;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        acc_en     = 1'b0;
        acc_hex    = 1'b0;
        acc_digit  = dec_val;
        unique case (phase_reg) inside
            ilrc_pkg::PH_START:
            begin
                if (in_char_reg == ilrc_pkg::ChPlus)
                begin
                    phase_next = ilrc_pkg::PH_SIGN;
                end
                else if (in_char_reg == ilrc_pkg::ChMinus)
                begin
                    neg_next   = 1'b1;
                    phase_next = ilrc_pkg::PH_SIGN;
                end
                else if (in_char_reg == ilrc_pkg::ChZero)
                begin
                    phase_next = ilrc_pkg::PH_ZERO;
                end
                else if (is_dec)
                begin
                    acc_en     = 1'b1;
                    phase_next = ilrc_pkg::PH_DEC;
                end
            end
            ilrc_pkg::PH_SIGN:
            begin
                if (in_char_reg == ilrc_pkg::ChZero)
                begin
                    phase_next = ilrc_pkg::PH_ZERO;
                end
                else if (is_dec)
                begin
                    acc_en     = 1'b1;
                    phase_next = ilrc_pkg::PH_DEC;
                end
            end
            ilrc_pkg::PH_ZERO:
            begin
                if ((in_char_reg == ilrc_pkg::ChLowerX) || (in_char_reg == ilrc_pkg::ChUpperX))
                begin
                    hex_next   = 1'b1;
                    phase_next = ilrc_pkg::PH_HEXPFX;
                end
                else if (is_dec)
                begin
                    acc_en     = 1'b1;
                    phase_next = ilrc_pkg::PH_DEC;
                end
            end
            ilrc_pkg::PH_DEC:
            begin
                if (is_dec)
                begin
                    acc_en     = 1'b1;
                    phase_next = ilrc_pkg::PH_DEC;
                end
            end
            ilrc_pkg::PH_HEXPFX, ilrc_pkg::PH_HEX:
            begin
                if (is_hex)
                begin
                    acc_en     = 1'b1;
                    acc_hex    = 1'b1;
                    acc_digit  = hex_val;
                    phase_next = ilrc_pkg::PH_HEX;
                end
            end
            default:
            begin
                phase_next = ilrc_pkg::PH_BAD;
            end
        endcase

        // Shift-add with four guard bits; anything in them means overflow
        wide = {4'b0, mag_reg};
        prod = acc_hex ? (wide << 4) : ((wide << 3) + (wide << 1));
        sum  = prod + {{MW{1'b0}}, acc_digit};
        if (acc_en && !ovf_reg)
        begin
            mag_next = sum[MW-1:0];
            ovf_next = (sum[MW+3:MW] != 4'b0);
        end
        else
        begin
            mag_next = mag_reg;
            ovf_next = ovf_reg;
        end

        ok_now = (phase_next == ilrc_pkg::PH_ZERO) || (phase_next == ilrc_pkg::PH_DEC)
              || (phase_next == ilrc_pkg::PH_HEX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ilrc_pkg::PH_START;
            neg_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            mag_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (proc && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                if (in_last_reg)
                begin
                    phase_reg     <= ilrc_pkg::PH_START;
                    neg_reg       <= 1'b0;
                    hex_reg       <= 1'b0;
                    mag_reg       <= '0;
                    ovf_reg       <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next;
                    neg_reg   <= neg_next;
                    hex_reg   <= hex_next;
                    mag_reg   <= mag_next;
                    ovf_reg   <= ovf_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc && in_last_reg)
        begin
            out_ok_reg  <= ok_now;
            out_neg_reg <= neg_next;
            out_ovf_reg <= ovf_next;
            out_mag_reg <= mag_next;
        end
    end

    // Range checks on the held magnitude
    always_comb
    begin
        fit = '0;
        for (int k = 0; k < ilrc_pkg::NumTypes - 1; k++)
        begin
            if (out_neg_reg)
            begin
                fit[k]   = ((out_mag_reg >> ((8 << k) - 1)) == '0)
                        || (out_mag_reg == (MW'(1) << ((8 << k) - 1)));
                fit[k+5] = (out_mag_reg == '0);
            end
            else
            begin
                fit[k]   = ((out_mag_reg >> ((8 << k) - 1)) == '0);
                fit[k+5] = ((out_mag_reg >> (8 << k)) == '0);
            end
        end
        if (out_neg_reg)
        begin
            fit[4] = !out_mag_reg[MW-1] || (out_mag_reg == (MW'(1) << (MW - 1)));
            fit[9] = 1'b0;
        end
        else
        begin
            fit[4] = !out_mag_reg[MW-1];
            fit[9] = 1'b1;
        end
        if (!out_ok_reg || out_ovf_reg)
        begin
            fit = '0;
        end
        m_axis_tdata = {4'b0, out_neg_reg, fit, out_ok_reg};
    end

endmodule

`default_nettype wire

/* bench/integer_literal_range_classifier_tb.sv */
`timescale 1ns / 1ps

module integer_literal_range_classifier_tb;

    localparam int ItemCount     = 1250;
    localparam int LongHold      = 300;
    localparam int WatchdogLimit = 2000;
    localparam int DrainCycles   = 8;

    typedef struct packed {
        logic [3:0] pad;
        logic       is_negative;
        logic [9:0] fit_mask;
        logic       is_integer;
    } class_result_t;

    class literal_scoreboard;
        ilrc_pkg::phase_t phase;
        bit               negative;
        logic [127:0]     magnitude;
        bit               overflow;
        class_result_t    expected_q[$];
        int               errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase     = ilrc_pkg::PH_START;
            negative  = 0;
            magnitude = '0;
            overflow  = 0;
        endfunction

        function int digit_of(logic [7:0] c, bit base16);
            if (c >= ilrc_pkg::ChZero && c <= ilrc_pkg::ChNine)
                return int'(c - ilrc_pkg::ChZero);
            if (base16 && c >= ilrc_pkg::ChLowerA && c <= ilrc_pkg::ChLowerF)
                return int'(c - ilrc_pkg::ChLowerA) + 10;
            if (base16 && c >= ilrc_pkg::ChUpperA && c <= ilrc_pkg::ChUpperF)
                return int'(c - ilrc_pkg::ChUpperA) + 10;
            return -1;
        endfunction

        // Shift-add in 132 bits; anything above bit 127 sets the sticky overflow.
        function void accumulate(bit base16, int digit);
            logic [131:0] t;
            if (overflow) return;
            t = base16 ? ({4'b0, magnitude} << 4) : ({4'b0, magnitude} * 10);
            t = t + 132'(digit);
            if (t[131:128] != 0) overflow = 1;
            else magnitude = t[127:0];
        endfunction

        function logic [9:0] range_fits();
            logic [9:0]   m;
            logic [127:0] smax;
            logic [127:0] umax;
            int           k;
            m = '0;
            if (overflow) return m;
            for (k = 0; k < 4; k++)
            begin
                smax = (128'd1 << ((8 << k) - 1)) - 1;
                umax = (128'd1 << (8 << k)) - 1;
                if (negative)
                begin
                    m[k]     = magnitude <= smax + 1;
                    m[k + 5] = magnitude == 0;   // negative zero still fits u8..u64
                end
                else
                begin
                    m[k]     = magnitude <= smax;
                    m[k + 5] = magnitude <= umax;
                end
            end
            m[4] = negative ? magnitude <= {1'b1, 127'b0} : magnitude <= {1'b0, {127{1'b1}}};
            m[9] = !negative;
            return m;
        endfunction

        function void note_char(logic [7:0] c, logic last);
            int               d;
            int               h;
            ilrc_pkg::phase_t nxt;
            class_result_t    r;
            d   = digit_of(c, 0);
            h   = digit_of(c, 1);
            nxt = ilrc_pkg::PH_BAD;
            case (phase) inside
                ilrc_pkg::PH_START:
                begin
                    if (c == ilrc_pkg::ChPlus) nxt = ilrc_pkg::PH_SIGN;
                    else if (c == ilrc_pkg::ChMinus)
                    begin
                        negative = 1;
                        nxt = ilrc_pkg::PH_SIGN;
                    end
                    else if (c == ilrc_pkg::ChZero) nxt = ilrc_pkg::PH_ZERO;
                    else if (d > 0)
                    begin
                        accumulate(0, d);
                        nxt = ilrc_pkg::PH_DEC;
                    end
                end
                ilrc_pkg::PH_SIGN:
                begin
                    if (c == ilrc_pkg::ChZero) nxt = ilrc_pkg::PH_ZERO;
                    else if (d > 0)
                    begin
                        accumulate(0, d);
                        nxt = ilrc_pkg::PH_DEC;
                    end
                end
                ilrc_pkg::PH_ZERO:
                begin
                    if (c == ilrc_pkg::ChLowerX || c == ilrc_pkg::ChUpperX)
                        nxt = ilrc_pkg::PH_HEXPFX;
                    else if (d >= 0)
                    begin
                        accumulate(0, d);
                        nxt = ilrc_pkg::PH_DEC;
                    end
                end
                ilrc_pkg::PH_DEC:
                begin
                    if (d >= 0)
                    begin
                        accumulate(0, d);
                        nxt = ilrc_pkg::PH_DEC;
                    end
                end
                ilrc_pkg::PH_HEXPFX, ilrc_pkg::PH_HEX:
                begin
                    if (h >= 0)
                    begin
                        accumulate(1, h);
                        nxt = ilrc_pkg::PH_HEX;
                    end
                end
                default: ;
            endcase
            phase = nxt;
            if (last)
            begin
                r.pad         = '0;
                r.is_integer  = phase inside {ilrc_pkg::PH_ZERO, ilrc_pkg::PH_DEC,
                                              ilrc_pkg::PH_HEX};
                r.fit_mask    = r.is_integer ? range_fits() : '0;
                r.is_negative = negative;
                expected_q.push_back(r);
                restart();
            end
        endfunction

        function void compare_field(string name, logic [9:0] exp_v, logic [9:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] data);
            class_result_t got;
            class_result_t exp_r;
            got = data;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, data);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("is_integer", 10'(exp_r.is_integer), 10'(got.is_integer));
            compare_field("fit_mask", exp_r.fit_mask, got.fit_mask);
            compare_field("is_negative", 10'(exp_r.is_negative), 10'(got.is_negative));
            compare_field("pad", 10'(exp_r.pad), 10'(got.pad));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    literal_scoreboard sb;
    logic [7:0]        literal_text[$];
    int                chars_sent = 0;
    int                idle_cycles = 0;
    bit                quiet = 0;
    bit                hold_request = 0;
    bit                hold_done = 0;

    integer_literal_range_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready) sb.note_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WatchdogLimit)
        begin
            $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: short random stalls, one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_axis_tready = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                stall_left = LongHold;
            end
            else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            if (stall_left > 0)
            begin
                m_axis_tready <= 0;
                stall_left--;
            end
            else
                m_axis_tready <= 1;
        end
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            s_axis_tvalid <= 0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        chars_sent++;
    endtask

    task automatic send_literal();
        foreach (literal_text[i]) send_char(literal_text[i], i == literal_text.size() - 1);
        literal_text.delete();
    endtask

    function automatic void append_str(string s);
        foreach (s[i]) literal_text.push_back(s[i]);
    endfunction

    function automatic logic [7:0] pick_x();
        return $urandom_range(0, 1) ? ilrc_pkg::ChUpperX : ilrc_pkg::ChLowerX;
    endfunction

    function automatic void append_number(logic [131:0] v, bit base16);
        logic [7:0] digits[$];
        logic [3:0] n;
        do
        begin
            if (base16)
            begin
                n = v[3:0];
                v = v >> 4;
            end
            else
            begin
                n = 4'(v % 10);
                v = v / 10;
            end
            if (n < 10) digits.push_front(ilrc_pkg::ChZero + 8'(n));
            else digits.push_front(($urandom_range(0, 1) ? ilrc_pkg::ChUpperA
                                                        : ilrc_pkg::ChLowerA)
                                   + 8'(n) - 8'd10);
        end
        while (v != 0);
        literal_text = {literal_text, digits};
    endfunction

    // Values around the type boundaries and of random widths, plus a few beyond 128 bits.
    function automatic logic [131:0] pick_value();
        int           edges[11] = '{7, 8, 15, 16, 31, 32, 63, 64, 127, 128, 129};
        logic [131:0] r;
        int           w;
        r = 132'({$urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 5))
            0:
            begin
                w = edges[$urandom_range(0, 10)];
                r = (132'd1 << w) + 132'($urandom_range(0, 2)) - 132'd1;
            end
            1: r = 132'($urandom_range(0, 300));
            2:
            begin
                w = $urandom_range(1, 130);
                r = r & ((132'd1 << w) - 1);
            end
            3: r = '0;
            default:
            begin
                w = $urandom_range(1, 40);
                r = r & ((132'd1 << w) - 1);
            end
        endcase
        return r;
    endfunction

    function automatic void build_wellformed();
        bit base16;
        base16 = $urandom_range(0, 2) == 0;
        case ($urandom_range(0, 2))
            1: literal_text.push_back(ilrc_pkg::ChPlus);
            2: literal_text.push_back(ilrc_pkg::ChMinus);
            default: ;
        endcase
        if (base16)
        begin
            literal_text.push_back(ilrc_pkg::ChZero);
            literal_text.push_back(pick_x());
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) literal_text.push_back(ilrc_pkg::ChZero);
        append_number(pick_value(), base16);
    endfunction

    function automatic void build_broken();
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 5)) literal_text.push_back(8'($urandom_range(0, 255)));
            1:
            begin
                build_wellformed();
                literal_text[$urandom_range(0, literal_text.size() - 1)] =
                    8'($urandom_range(0, 255));
            end
            2:
            begin
                // sign and/or prefix with nothing after
                if ($urandom_range(0, 1))
                    literal_text.push_back($urandom_range(0, 1) ? ilrc_pkg::ChPlus
                                                                : ilrc_pkg::ChMinus);
                if ($urandom_range(0, 1))
                begin
                    literal_text.push_back(ilrc_pkg::ChZero);
                    literal_text.push_back(pick_x());
                end
                if (literal_text.size() == 0) literal_text.push_back(ilrc_pkg::ChMinus);
            end
            default:
            begin
                build_wellformed();
                literal_text.push_back(ilrc_pkg::ChLowerA + 8'($urandom_range(0, 6)));
            end
        endcase
    endfunction

    initial
    begin
        sb = new();
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tlast = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        append_str("-");     send_literal();
        append_str("0x");    send_literal();
        append_str("+0X1f"); send_literal();
        append_str("-0");    send_literal();
        append_str("-0x0");  send_literal();
        append_str("12a");   send_literal();
        append_str("0");     send_literal();
        append_str("+");     send_literal();
        append_str("-9");    send_literal();
        literal_text.push_back(8'hFF);
        literal_text.push_back(8'h00);
        send_literal();

        while (chars_sent < ItemCount)
        begin
            if ($urandom_range(0, 4) == 0) build_broken();
            else build_wellformed();
            if (chars_sent > 400 && !hold_done)
            begin
                hold_request = 1;
                hold_done = 1;
            end
            quiet = chars_sent > ItemCount * 5 / 6;
            send_literal();
        end
        @(negedge clk);
        s_axis_tvalid <= 0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
rtl/ilrc_pkg.sv
rtl/integer_literal_range_classifier.sv
bench/integer_literal_range_classifier_tb.sv
